// File: hw/rtl/mfu_pkg.sv
`timescale 1ns / 1ps

package mfu_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] key;
        logic        [63:0] value;
    } mfu_in_t;

    typedef struct packed {
        logic               hit;
        logic        [63:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } mfu_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_POST,
        ST_EMIT
    } mfu_state_t;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic post;
        logic emit;
    } mfu_ctrl_t;

endpackage

// File: hw/rtl/mfu_store.sv
`timescale 1ns / 1ps

module mfu_store
    import mfu_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 32,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic                   rd_valid,
    output logic [31:0]            rd_key,
    output logic [63:0]            rd_data,
    output logic [COUNT_WIDTH-1:0] rd_count,
    output logic [IDX_W-1:0]       rd_rank,
    input  logic                   rank_we,
    input  logic [IDX_W-1:0]       rank_waddr,
    input  logic [IDX_W-1:0]       rank_wdata,
    input  logic                   ent_we,
    input  logic [IDX_W-1:0]       ent_waddr,
    input  logic [31:0]            ent_wkey,
    input  logic [63:0]            ent_wdata,
    input  logic                   cnt_we,
    input  logic [IDX_W-1:0]       cnt_waddr,
    input  logic [COUNT_WIDTH-1:0] cnt_wdata,
    input  logic                   vclr_en,
    input  logic [IDX_W-1:0]       vclr_idx,
    input  logic                   vset_en,
    input  logic [IDX_W-1:0]       vset_idx
);

    logic [31:0]            key_mem   [DEPTH];
    logic [63:0]            data_mem  [DEPTH];
    logic [COUNT_WIDTH-1:0] count_mem [DEPTH];
    logic [IDX_W-1:0]       rank_mem  [DEPTH];

    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;

    logic                   valid_rd_reg;
    logic [31:0]            key_rd_reg;
    logic [63:0]            data_rd_reg;
    logic [COUNT_WIDTH-1:0] count_rd_reg;
    logic [IDX_W-1:0]       rank_rd_reg;

    // Set wins over clear when the victim slot is refilled
    always_comb begin
        valid_next = valid_reg;
        if (vclr_en) begin
            valid_next[vclr_idx] = 1'b0;
        end
        if (vset_en) begin
            valid_next[vset_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            key_mem[ent_waddr]  <= ent_wkey;
            data_mem[ent_waddr] <= ent_wdata;
        end
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        valid_rd_reg <= valid_reg[rd_addr];
        key_rd_reg   <= key_mem[rd_addr];
        data_rd_reg  <= data_mem[rd_addr];
        count_rd_reg <= count_mem[rd_addr];
        rank_rd_reg  <= rank_mem[rd_addr];
    end

    assign rd_valid = valid_rd_reg;
    assign rd_key   = key_rd_reg;
    assign rd_data  = data_rd_reg;
    assign rd_count = count_rd_reg;
    assign rd_rank  = rank_rd_reg;

endmodule

// File: hw/rtl/mfu_unit.sv
`timescale 1ns / 1ps

module mfu_unit
    import mfu_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 32,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int OCC_W      = $clog2(DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mfu_ctrl_t              ctrl,
    input  mfu_in_t                item_in,
    input  logic [CAP_W-1:0]       capacity,
    input  logic [IDX_W-1:0]       rd_idx,
    input  logic                   rd_valid,
    input  logic [31:0]            rd_key,
    input  logic [63:0]            rd_data,
    input  logic [COUNT_WIDTH-1:0] rd_count,
    input  logic [IDX_W-1:0]       rd_rank,
    output logic                   rank_we,
    output logic [IDX_W-1:0]       rank_waddr,
    output logic [IDX_W-1:0]       rank_wdata,
    output logic                   ent_we,
    output logic [IDX_W-1:0]       ent_waddr,
    output logic [31:0]            ent_wkey,
    output logic [63:0]            ent_wdata,
    output logic                   cnt_we,
    output logic [IDX_W-1:0]       cnt_waddr,
    output logic [COUNT_WIDTH-1:0] cnt_wdata,
    output logic                   vclr_en,
    output logic [IDX_W-1:0]       vclr_idx,
    output logic                   vset_en,
    output logic [IDX_W-1:0]       vset_idx,
    output logic                   need_update,
    output mfu_out_t               result,
    output logic [OCC_W-1:0]       occupancy
);

    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    mfu_in_t                item_reg;

    logic                   found_reg;
    logic [IDX_W-1:0]       found_idx_reg;
    logic [IDX_W-1:0]       found_rank_reg;
    logic [COUNT_WIDTH-1:0] found_count_reg;
    logic [63:0]            found_data_reg;

    logic                   vic_reg;
    logic [IDX_W-1:0]       vic_idx_reg;
    logic [31:0]            vic_key_reg;
    logic [COUNT_WIDTH-1:0] vic_count_reg;
    logic [IDX_W-1:0]       vic_rank_reg;

    logic                   free_reg;
    logic [IDX_W-1:0]       free_idx_reg;

    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;

    logic                   hit_now;
    logic                   vic_now;
    logic                   free_now;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   is_put;
    logic                   do_evict;
    logic                   do_ins;
    logic [IDX_W-1:0]       slot;

    // Per-entry compare during the scan sweep
    assign hit_now  = ctrl.scan && rd_valid && (rd_key == item_reg.key) && !found_reg;
    assign vic_now  = ctrl.scan && rd_valid &&
                      (!vic_reg || (rd_count > vic_count_reg) ||
                       ((rd_count == vic_count_reg) && (rd_rank > vic_rank_reg)));
    assign free_now = ctrl.scan && !rd_valid && !free_reg;

    // Occupancy advances only as the result leaves, so the eviction decision
    // holds from commit through emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            vic_reg   <= 1'b0;
            free_reg  <= 1'b0;
            occ_reg   <= '0;
        end else begin
            if (ctrl.load) begin
                found_reg <= 1'b0;
                vic_reg   <= 1'b0;
                free_reg  <= 1'b0;
            end else begin
                if (hit_now) begin
                    found_reg <= 1'b1;
                end
                if (vic_now) begin
                    vic_reg <= 1'b1;
                end
                if (free_now) begin
                    free_reg <= 1'b1;
                end
            end
            if (ctrl.emit) begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            item_reg <= item_in;
        end
        if (hit_now) begin
            found_idx_reg   <= rd_idx;
            found_rank_reg  <= rd_rank;
            found_count_reg <= rd_count;
            found_data_reg  <= rd_data;
        end
        if (vic_now) begin
            vic_idx_reg   <= rd_idx;
            vic_key_reg   <= rd_key;
            vic_count_reg <= rd_count;
            vic_rank_reg  <= rd_rank;
        end
        if (free_now) begin
            free_idx_reg <= rd_idx;
        end
    end

    // Clamp capacity into 1..DEPTH
    assign cap_ext = CMP_W'(capacity);

    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign is_put   = (item_reg.kind == KIND_PUT);
    assign do_evict = is_put && !found_reg && vic_reg && (CMP_W'(occ_reg) >= eff_cap);
    assign do_ins   = is_put && !found_reg && (free_reg || do_evict);
    // First empty slot once the victim is gone
    assign slot     = (free_reg && (!do_evict || (free_idx_reg < vic_idx_reg))) ?
                      free_idx_reg : vic_idx_reg;

    assign need_update = found_reg || do_ins;
    assign occ_next    = occ_reg + OCC_W'(do_ins) - OCC_W'(do_evict);
    assign occupancy   = occ_reg;

    // Rank rewrite: aging sweep (a hit entry becomes most recent in it), then an inserted entry becomes most recent
    always_comb begin
        rank_we    = 1'b0;
        rank_waddr = rd_idx;
        rank_wdata = rd_rank;
        if (ctrl.update && rd_valid) begin
            if (found_reg) begin
                rank_we = 1'b1;
                if (rd_idx == found_idx_reg) begin
                    rank_wdata = '0;
                end else if (rd_rank < found_rank_reg) begin
                    rank_wdata = rd_rank + IDX_W'(1);
                end
            end else if (!(do_evict && (rd_idx == vic_idx_reg))) begin
                rank_we = 1'b1;
                // Older than the victim: close the gap and age by one, net zero
                if (!(do_evict && (rd_rank > vic_rank_reg))) begin
                    rank_wdata = rd_rank + IDX_W'(1);
                end
            end
        end else if (ctrl.post && do_ins) begin
            rank_we    = 1'b1;
            rank_waddr = slot;
            rank_wdata = '0;
        end
    end

    always_comb begin
        cnt_we    = ctrl.post && (found_reg || do_ins);
        cnt_waddr = found_reg ? found_idx_reg : slot;
        if (!found_reg) begin
            cnt_wdata = COUNT_WIDTH'(1);
        end else if (found_count_reg == '1) begin
            cnt_wdata = found_count_reg;
        end else begin
            cnt_wdata = found_count_reg + COUNT_WIDTH'(1);
        end
    end

    assign ent_we    = ctrl.post && do_ins;
    assign ent_waddr = slot;
    assign ent_wkey  = item_reg.key;
    assign ent_wdata = item_reg.value;
    assign vclr_en   = ctrl.post && do_evict;
    assign vclr_idx  = vic_idx_reg;
    assign vset_en   = ctrl.post && do_ins;
    assign vset_idx  = slot;

    assign result.hit         = found_reg;
    assign result.read_value  = found_reg ? found_data_reg : 64'd0;
    assign result.evicted     = do_evict;
    assign result.evicted_key = do_evict ? vic_key_reg : 32'd0;

endmodule

// File: hw/rtl/mfu_seq.sv
`timescale 1ns / 1ps

module mfu_seq
    import mfu_pkg::*;
#(
    parameter int DEPTH  = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             need_update,
    input  logic             out_free,
    output logic             s_ready,
    output mfu_ctrl_t        ctrl,
    output logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] rd_idx
);

    mfu_state_t       state_reg;
    mfu_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;

    logic             issue;
    logic             done;

    assign issue = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) &&
                   (cnt_reg < CNT_W'(DEPTH));
    assign done  = (cnt_reg == CNT_W'(DEPTH)) && !rd_vld_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done) begin
                    state_next = need_update ? ST_UPDATE : ST_EMIT;
                end
            end
            ST_UPDATE: begin
                if (done) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        ctrl.load   = (state_reg == ST_IDLE) && s_valid;
        ctrl.scan   = (state_reg == ST_SCAN) && rd_vld_reg;
        ctrl.update = (state_reg == ST_UPDATE) && rd_vld_reg;
        ctrl.post   = (state_reg == ST_POST);
        ctrl.emit   = (state_reg == ST_EMIT) && out_free;
        rd_addr     = issue ? cnt_reg[IDX_W-1:0] : '0;
        rd_idx      = rd_idx_reg;
    end

    // Restart the sweep counter on every state change
    always_comb begin
        if (state_next != state_reg) begin
            cnt_next = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end
        rd_vld_next = issue;
        rd_idx_next = rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
    end

endmodule

// File: hw/rtl/mfu_cache_replacement_top.sv
`timescale 1ns / 1ps
// Most-frequently-used replacement cache, fully associative, DEPTH entries.
// Input channel (s_valid/s_ready/s_data): one get or put item per handshake.
// Result channel (m_valid/m_ready/m_data): exactly one result item per input item,
// in order: hit, the value read on a hit, and the evicted key when a put made room.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes the capacity register;
// always ready, write only while no item is in flight.
// Path: a get that misses runs the scan sweep and then emits; a hit or a put runs the
// scan sweep, rank sweep, commit and emit. The sweeps are paced by the shared compare
// unit, which sees one entry per cycle through the single read port of the entry
// memories. One item is in work at a time; s_ready is high only while the sequencer
// idles, so a new item is taken only after the previous result has entered the
// output register.
// The output register holds a finished result, so the next item is accepted while
// the previous result still waits; a stalled receiver holds m_data steady and the
// sequencer waits to emit until the output register frees.
// Reset (aresetn low, synchronous) clears all valid bits, occupancy and the output
// valid flag, and sets capacity to 16. No clearing pass is needed.
module mfu_cache_replacement_top
    import mfu_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mfu_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mfu_out_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [CAP_W-1:0]       capacity_reg;
    logic                   m_valid_reg;
    mfu_out_t               m_data_reg;

    mfu_ctrl_t              ctrl;
    logic                   need_update;
    logic                   out_free;
    mfu_out_t               result;
    logic [OCC_W-1:0]       occupancy;

    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       rd_idx;
    logic                   rd_valid;
    logic [31:0]            rd_key;
    logic [63:0]            rd_data;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [IDX_W-1:0]       rd_rank;

    logic                   rank_we;
    logic [IDX_W-1:0]       rank_waddr;
    logic [IDX_W-1:0]       rank_wdata;
    logic                   ent_we;
    logic [IDX_W-1:0]       ent_waddr;
    logic [31:0]            ent_wkey;
    logic [63:0]            ent_wdata;
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   vclr_en;
    logic [IDX_W-1:0]       vclr_idx;
    logic                   vset_en;
    logic [IDX_W-1:0]       vset_idx;

    // Config: capacity is taken on every write handshake
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    // Output register: free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer: scan sweep, rank sweep, commit, emit
    mfu_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .need_update (need_update),
        .out_free    (out_free),
        .s_ready     (s_ready),
        .ctrl        (ctrl),
        .rd_addr     (rd_addr),
        .rd_idx      (rd_idx)
    );

    // Shared compare and update unit, one entry per cycle
    mfu_unit #(
        .DEPTH       (DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .item_in     (s_data),
        .capacity    (capacity_reg),
        .rd_idx      (rd_idx),
        .rd_valid    (rd_valid),
        .rd_key      (rd_key),
        .rd_data     (rd_data),
        .rd_count    (rd_count),
        .rd_rank     (rd_rank),
        .rank_we     (rank_we),
        .rank_waddr  (rank_waddr),
        .rank_wdata  (rank_wdata),
        .ent_we      (ent_we),
        .ent_waddr   (ent_waddr),
        .ent_wkey    (ent_wkey),
        .ent_wdata   (ent_wdata),
        .cnt_we      (cnt_we),
        .cnt_waddr   (cnt_waddr),
        .cnt_wdata   (cnt_wdata),
        .vclr_en     (vclr_en),
        .vclr_idx    (vclr_idx),
        .vset_en     (vset_en),
        .vset_idx    (vset_idx),
        .need_update (need_update),
        .result      (result),
        .occupancy   (occupancy)
    );

    // Entry memories and valid bits
    mfu_store #(
        .DEPTH       (DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_addr    (rd_addr),
        .rd_valid   (rd_valid),
        .rd_key     (rd_key),
        .rd_data    (rd_data),
        .rd_count   (rd_count),
        .rd_rank    (rd_rank),
        .rank_we    (rank_we),
        .rank_waddr (rank_waddr),
        .rank_wdata (rank_wdata),
        .ent_we     (ent_we),
        .ent_waddr  (ent_waddr),
        .ent_wkey   (ent_wkey),
        .ent_wdata  (ent_wdata),
        .cnt_we     (cnt_we),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .vclr_en    (vclr_en),
        .vclr_idx   (vclr_idx),
        .vset_en    (vset_en),
        .vset_idx   (vset_idx)
    );

    // Occupancy never passes the number of entries
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= OCC_W'(DEPTH))
        else $error("occupancy above DEPTH");

    // An emitted result lands in the output register
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |=> m_valid)
        else $error("emitted result not presented");

    // An accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready while an item is in work");

endmodule
